>>> rtl/ufl_pkg.sv
package ufl_pkg;

    localparam int FLOW_COUNT = 64;
    localparam int IDX_W      = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
    localparam int MASK_W     = 64;
    localparam int SLOT_W     = 6;
    localparam logic [31:0] IDLE_RESET = 32'd60;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FLOW_COUNT - 1);

    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_REFRESH = 2'd1,
        OP_CLOSE   = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [31:0]      addr;
        logic [15:0]      port;
        logic [IDX_W-1:0] idx;
        logic             in_range;
        logic [31:0]      now;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              evicted;
        logic              ignored;
        logic [MASK_W-1:0] closed_mask;
    } res_t;

    // Low six bits of a table index, as reported in the slot field.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [15:0] wide;
        wide = 16'(idx);
        return wide[SLOT_W-1:0];
    endfunction

    // True when the index has a bit of its own in the closed mask.
    function automatic logic has_mask_bit(input logic [IDX_W-1:0] idx);
        return 16'(idx) < 16'(MASK_W);
    endfunction

endpackage

>>> rtl/ufl_front.sv
module ufl_front
    import ufl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [31:0] client_addr,
    input  logic [15:0] client_port,
    input  logic [5:0]  slot_index,
    input  logic [31:0] now_seconds,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_take
);

    cmd_t        cmd_q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        cmd_in;
    logic [15:0] idx_wide;
    logic        accept;

    // Decode the request into the form the back end works on.
    always_comb
    begin
        idx_wide         = 16'(slot_index);
        cmd_in.op        = op_t'(op);
        cmd_in.addr      = client_addr;
        cmd_in.port      = client_port;
        cmd_in.idx       = idx_wide[IDX_W-1:0];
        cmd_in.in_range  = idx_wide < 16'(FLOW_COUNT);
        cmd_in.now       = now_seconds;
    end

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = cmd_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ accept;
        rd_ptr_next = rd_ptr_reg ^ cmd_take;
        cnt_next    = cnt_reg + 2'(accept) - 2'(cmd_take);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/ufl_engine.sv
module ufl_engine
    import ufl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] idle_limit,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic        res_valid,
    output res_t        res,
    input  logic        res_take
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [IDX_W-1:0]  issue_addr_reg, issue_addr_next;
    logic              issue_on_reg, issue_on_next;
    logic              cmp_on_reg, cmp_on_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              free_on_reg, free_on_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  old_idx_reg, old_idx_next;
    logic [31:0]       old_time_reg, old_time_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [FLOW_COUNT-1:0] valid_reg, valid_next;

    logic [47:0]       key_mem [FLOW_COUNT];
    logic [31:0]       time_mem [FLOW_COUNT];
    logic [47:0]       rd_key_reg;
    logic [31:0]       rd_time_reg;
    logic              key_we;
    logic [IDX_W-1:0]  key_wa;
    logic              time_we;
    logic [IDX_W-1:0]  time_wa;
    logic [31:0]       time_wd;

    res_t              out_q_reg [2];
    logic              out_wr_reg, out_rd_reg;
    logic [1:0]        out_cnt_reg;
    logic              res_push;
    res_t              res_in;

    logic [31:0]       age;
    logic              cmp_valid;
    logic              key_match;
    logic [IDX_W-1:0]  alloc_idx;

    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid && (out_cnt_reg != 2'd2);
    assign age       = cur_reg.now - rd_time_reg;
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign key_match = cmp_valid && (rd_key_reg == {cur_reg.addr, cur_reg.port});
    assign alloc_idx = free_on_reg ? free_idx_reg : old_idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        issue_addr_next = issue_addr_reg;
        issue_on_next   = 1'b0;
        cmp_on_next     = issue_on_reg;
        cmp_idx_next    = issue_addr_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        free_on_next    = free_on_reg;
        free_idx_next   = free_idx_reg;
        old_idx_next    = old_idx_reg;
        old_time_next   = old_time_reg;
        mask_next       = mask_reg;
        valid_next      = valid_reg;
        key_we          = 1'b0;
        key_wa          = alloc_idx;
        time_we         = 1'b0;
        time_wa         = cur_reg.idx;
        time_wd         = cur_reg.now;
        res_push        = 1'b0;
        res_in          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    cur_next = cmd;
                    case (cmd.op) inside
                        OP_LOOKUP, OP_TICK:
                        begin
                            state_next      = ST_SCAN;
                            issue_addr_next = '0;
                            issue_on_next   = 1'b1;
                            found_next      = 1'b0;
                            free_on_next    = 1'b0;
                            mask_next       = '0;
                        end
                        default:
                        begin
                            // Refresh and close act on one slot right away.
                            res_push    = 1'b1;
                            res_in.slot = slot_of(cmd.idx);
                            if (!cmd.in_range || !valid_reg[cmd.idx])
                            begin
                                res_in.ignored = 1'b1;
                            end
                            else if (cmd.op == OP_REFRESH)
                            begin
                                time_we = 1'b1;
                                time_wa = cmd.idx;
                                time_wd = cmd.now;
                            end
                            else
                            begin
                                valid_next[cmd.idx] = 1'b0;
                                if (has_mask_bit(cmd.idx))
                                begin
                                    res_in.closed_mask[slot_of(cmd.idx)] = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue_on_reg && (issue_addr_reg != IDX_LAST))
                begin
                    issue_on_next   = 1'b1;
                    issue_addr_next = issue_addr_reg + 1'b1;
                end
                if (cmp_on_reg)
                begin
                    if (cur_reg.op == OP_TICK)
                    begin
                        if (cmp_valid && (age >= idle_limit))
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            if (has_mask_bit(cmp_idx_reg))
                            begin
                                mask_next[slot_of(cmp_idx_reg)] = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (key_match && !found_reg)
                        begin
                            found_next   = 1'b1;
                            hit_idx_next = cmp_idx_reg;
                        end
                        if (!cmp_valid && !free_on_reg)
                        begin
                            free_on_next  = 1'b1;
                            free_idx_next = cmp_idx_reg;
                        end
                        if ((cmp_idx_reg == '0) || (rd_time_reg < old_time_reg))
                        begin
                            old_idx_next  = cmp_idx_reg;
                            old_time_next = rd_time_reg;
                        end
                    end
                    if (cmp_idx_reg == IDX_LAST)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
                res_push   = 1'b1;
                if (cur_reg.op == OP_TICK)
                begin
                    res_in.closed_mask = mask_reg;
                end
                else if (found_reg)
                begin
                    res_in.slot = slot_of(hit_idx_reg);
                    res_in.hit  = 1'b1;
                    time_we     = 1'b1;
                    time_wa     = hit_idx_reg;
                end
                else
                begin
                    res_in.slot          = slot_of(alloc_idx);
                    res_in.evicted       = !free_on_reg;
                    key_we               = 1'b1;
                    time_we              = 1'b1;
                    time_wa              = alloc_idx;
                    valid_next[alloc_idx] = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= {cur_reg.addr, cur_reg.port};
        end
        if (time_we)
        begin
            time_mem[time_wa] <= time_wd;
        end
        rd_key_reg  <= key_mem[issue_addr_reg];
        rd_time_reg <= time_mem[issue_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        issue_addr_reg <= issue_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        old_idx_reg    <= old_idx_next;
        old_time_reg   <= old_time_next;
        mask_reg       <= mask_next;
        if (res_push)
        begin
            out_q_reg[out_wr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_on_reg <= 1'b0;
            cmp_on_reg   <= 1'b0;
            found_reg    <= 1'b0;
            free_on_reg  <= 1'b0;
            valid_reg    <= '0;
            out_wr_reg   <= 1'b0;
            out_rd_reg   <= 1'b0;
            out_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_on_reg <= issue_on_next;
            cmp_on_reg   <= cmp_on_next;
            found_reg    <= found_next;
            free_on_reg  <= free_on_next;
            valid_reg    <= valid_next;
            out_wr_reg   <= out_wr_reg ^ res_push;
            out_rd_reg   <= out_rd_reg ^ res_take;
            out_cnt_reg  <= out_cnt_reg + 2'(res_push) - 2'(res_take);
        end
    end

    assign res_valid = (out_cnt_reg != 2'd0);
    assign res       = out_q_reg[out_rd_reg];

endmodule

>>> rtl/udp_flow_table_lru_aging.sv
// Channel   Direction  Handshake             Contents
// request   in         push / full           op, client_addr, client_port, slot_index,
//                                            now_seconds
// result    out        empty / pop           slot, hit, evicted, ignored, closed_mask
// config    in         cfg_wr_en (no wait)   cfg_wr_data -> idle_limit
//
// A lookup or an aging tick walks all FLOW_COUNT table entries through the
// one read port of the flow memory in the back end; a refresh or close
// acts on its one slot directly.
// The front end holds up to two requests and the result queue up to two
// results, so each side may stall without holding up the other.
// Reset clears the valid marks and the queues at once; no clearing pass.
module udp_flow_table_lru_aging
    import ufl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [31:0] client_addr,
    input  logic [15:0] client_port,
    input  logic [5:0]  slot_index,
    input  logic [31:0] now_seconds,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  slot,
    output logic        hit,
    output logic        evicted,
    output logic        ignored,
    output logic [63:0] closed_mask
);

    // The user must change the idle limit only while the block is idle; the block does not enforce it.
    logic [31:0] idle_limit_reg;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_take;
    logic        res_valid;
    res_t        res;
    logic        res_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            idle_limit_reg <= cfg_wr_data;
        end
    end

    // The front end decodes each request and queues it for the engine.
    ufl_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .client_addr (client_addr),
        .client_port (client_port),
        .slot_index  (slot_index),
        .now_seconds (now_seconds),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    // The engine owns the flow table and the result queue.
    ufl_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .idle_limit (idle_limit_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    assign empty       = !res_valid;
    assign res_take    = pop && res_valid;
    assign slot        = res.slot;
    assign hit         = res.hit;
    assign evicted     = res.evicted;
    assign ignored     = res.ignored;
    assign closed_mask = res.closed_mask;

endmodule
